// ----- rtl/stsd_pkg.sv -----
// shared types, constants and arithmetic steps of the sphere triangle subdivider
package stsd_pkg;

    localparam int COMP_W    = 16;
    localparam int MAG_W     = 17;
    localparam int SQR_W     = 34;
    localparam int RAD_W     = 36;
    localparam int REM_W     = 21;
    localparam int ROOT_W    = 18;
    localparam int DREM_W    = 19;
    localparam int QUO_W     = 16;
    localparam int SQ_STAGES = 9;
    localparam int SQ_STEPS  = 2;
    localparam int DV_STAGES = 8;
    localparam int DV_STEPS  = 2;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam logic [QUO_W-1:0] UNIT_Q14 = 16'd16384;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_C,
        PH_MID
    } t_phase;

    typedef logic [2:0][COMP_W-1:0] t_vec;

    typedef struct packed {
        t_vec a;
        t_vec b;
        t_vec c;
        logic last;
    } t_corner;

    typedef struct packed {
        t_vec p0;
        t_vec p1;
        t_vec p2;
        logic last_of_four;
        logic mesh_end;
    } t_tri;

    typedef struct packed {
        logic [REM_W-1:0]       rem;
        logic [ROOT_W-1:0]      root;
        logic [RAD_W-1:0]       rad;
        logic [2:0][MAG_W-1:0]  mag;
        logic [2:0]             neg;
    } t_sq_st;

    typedef struct packed {
        logic [2:0][DREM_W-1:0] rem;
        logic [2:0][QUO_W-1:0]  quo;
        logic [2:0][QUO_W-1:0]  nlo;
        logic [ROOT_W-1:0]      den;
        logic                   zero;
        logic [2:0]             neg;
    } t_dv_st;

    // one digit of the restoring square root, two radicand bits in
    function automatic t_sq_st sqrt_step(t_sq_st st);
        t_sq_st o;
        logic [REM_W-1:0] t;
        logic [REM_W-1:0] trial;
        o     = st;
        t     = {st.rem[REM_W-3:0], st.rad[RAD_W-1:RAD_W-2]};
        trial = {1'b0, st.root, 2'b01};
        o.rad = {st.rad[RAD_W-3:0], 2'b00};
        if (t >= trial) begin
            o.rem  = t - trial;
            o.root = {st.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = t;
            o.root = {st.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit of the restoring divide, for all three components
    function automatic t_dv_st div_step(t_dv_st st);
        t_dv_st o;
        logic [DREM_W-1:0] t;
        o = st;
        for (int k = 0; k < 3; k++) begin
            t        = {st.rem[k][DREM_W-2:0], st.nlo[k][QUO_W-1]};
            o.nlo[k] = {st.nlo[k][QUO_W-2:0], 1'b0};
            if (t >= {1'b0, st.den}) begin
                o.rem[k] = t - {1'b0, st.den};
                o.quo[k] = {st.quo[k][QUO_W-2:0], 1'b1};
            end else begin
                o.rem[k] = t;
                o.quo[k] = {st.quo[k][QUO_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

endpackage

// ----- rtl/stsd_lane.sv -----
// one midpoint lane: sum, squared length, pipelined square root and divide
module stsd_lane (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  stsd_pkg::t_vec i_p,
    input  stsd_pkg::t_vec i_q,
    output logic          o_vld,
    output stsd_pkg::t_vec o_m
);

    logic                               r_a_vld;
    logic [2:0][stsd_pkg::MAG_W-1:0]    n_a_mag, r_a_mag;
    logic [2:0]                         n_a_neg, r_a_neg;
    logic [2:0][stsd_pkg::SQR_W-1:0]    n_a_sq, r_a_sq;

    logic                               r_b_vld;
    logic [stsd_pkg::SQR_W-1:0]         n_b_sum, r_b_sum;

    stsd_pkg::t_sq_st w_sq_src [stsd_pkg::SQ_STAGES];
    logic             w_sq_vsrc [stsd_pkg::SQ_STAGES];
    stsd_pkg::t_sq_st n_sq [stsd_pkg::SQ_STAGES];
    stsd_pkg::t_sq_st r_sq [stsd_pkg::SQ_STAGES];
    logic             r_sq_vld [stsd_pkg::SQ_STAGES];

    logic             r_p_vld;
    stsd_pkg::t_dv_st n_p, r_p;

    stsd_pkg::t_dv_st w_dv_src [stsd_pkg::DV_STAGES];
    logic             w_dv_vsrc [stsd_pkg::DV_STAGES];
    stsd_pkg::t_dv_st n_dv [stsd_pkg::DV_STAGES];
    stsd_pkg::t_dv_st r_dv [stsd_pkg::DV_STAGES];
    logic             r_dv_vld [stsd_pkg::DV_STAGES];

    logic             r_f_vld;
    stsd_pkg::t_vec   n_f, r_f;

    // edge sum, magnitude and squares
    always_comb begin
        logic [stsd_pkg::MAG_W-1:0] s;
        for (int k = 0; k < 3; k++) begin
            s = {i_p[k][stsd_pkg::COMP_W-1], i_p[k]} + {i_q[k][stsd_pkg::COMP_W-1], i_q[k]};
            n_a_neg[k] = s[stsd_pkg::MAG_W-1];
            n_a_mag[k] = s[stsd_pkg::MAG_W-1] ? (~s + 17'd1) : s;
            n_a_sq[k]  = stsd_pkg::SQR_W'(n_a_mag[k]) * stsd_pkg::SQR_W'(n_a_mag[k]);
        end
    end

    assign n_b_sum = r_a_sq[0] + r_a_sq[1] + r_a_sq[2];

    always_ff @(posedge i_clk) begin
        r_a_mag <= n_a_mag;
        r_a_neg <= n_a_neg;
        r_a_sq  <= n_a_sq;
        r_b_sum <= n_b_sum;
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
    end

    // magnitude and sign ride along with the root
    logic [2:0][stsd_pkg::MAG_W-1:0] r_b_mag;
    logic [2:0]                      r_b_neg;
    always_ff @(posedge i_clk) begin
        r_b_mag <= r_a_mag;
        r_b_neg <= r_a_neg;
    end

    genvar j;
    generate
        for (j = 0; j < stsd_pkg::SQ_STAGES; j++) begin : g_sq
            if (j == 0) begin : g_first
                always_comb begin
                    w_sq_src[j].rem  = '0;
                    w_sq_src[j].root = '0;
                    w_sq_src[j].rad  = stsd_pkg::RAD_W'(r_b_sum);
                    w_sq_src[j].mag  = r_b_mag;
                    w_sq_src[j].neg  = r_b_neg;
                    w_sq_vsrc[j]     = r_b_vld;
                end
            end else begin : g_next
                assign w_sq_src[j]  = r_sq[j-1];
                assign w_sq_vsrc[j] = r_sq_vld[j-1];
            end
            always_comb begin
                stsd_pkg::t_sq_st st;
                st = w_sq_src[j];
                for (int s = 0; s < stsd_pkg::SQ_STEPS; s++) begin
                    st = stsd_pkg::sqrt_step(st);
                end
                n_sq[j] = st;
            end
            always_ff @(posedge i_clk) begin
                r_sq[j] <= n_sq[j];
                if (!i_rst_n) begin
                    r_sq_vld[j] <= 1'b0;
                end else begin
                    r_sq_vld[j] <= w_sq_vsrc[j];
                end
            end
        end
    endgenerate

    // numerator |s|*2^15 + L, divisor 2L; the top 17 bits start the remainder
    always_comb begin
        logic [stsd_pkg::ROOT_W-1:0] len;
        logic [32:0]                 num;
        len = r_sq[stsd_pkg::SQ_STAGES-1].root;
        for (int k = 0; k < 3; k++) begin
            num = 33'({r_sq[stsd_pkg::SQ_STAGES-1].mag[k], 15'b0}) + 33'(len);
            n_p.rem[k] = {2'b00, num[32:16]};
            n_p.nlo[k] = num[15:0];
            n_p.quo[k] = '0;
        end
        n_p.den  = {len[stsd_pkg::ROOT_W-2:0], 1'b0};
        n_p.zero = (len == '0);
        n_p.neg  = r_sq[stsd_pkg::SQ_STAGES-1].neg;
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= r_sq_vld[stsd_pkg::SQ_STAGES-1];
        end
    end

    generate
        for (j = 0; j < stsd_pkg::DV_STAGES; j++) begin : g_dv
            if (j == 0) begin : g_first
                assign w_dv_src[j]  = r_p;
                assign w_dv_vsrc[j] = r_p_vld;
            end else begin : g_next
                assign w_dv_src[j]  = r_dv[j-1];
                assign w_dv_vsrc[j] = r_dv_vld[j-1];
            end
            always_comb begin
                stsd_pkg::t_dv_st st;
                st = w_dv_src[j];
                for (int s = 0; s < stsd_pkg::DV_STEPS; s++) begin
                    st = stsd_pkg::div_step(st);
                end
                n_dv[j] = st;
            end
            always_ff @(posedge i_clk) begin
                r_dv[j] <= n_dv[j];
                if (!i_rst_n) begin
                    r_dv_vld[j] <= 1'b0;
                end else begin
                    r_dv_vld[j] <= w_dv_vsrc[j];
                end
            end
        end
    endgenerate

    // clamp, zero-length bypass and sign
    always_comb begin
        logic [stsd_pkg::QUO_W-1:0] q;
        for (int k = 0; k < 3; k++) begin
            q = r_dv[stsd_pkg::DV_STAGES-1].quo[k];
            if (q > stsd_pkg::UNIT_Q14) begin
                q = stsd_pkg::UNIT_Q14;
            end
            if (r_dv[stsd_pkg::DV_STAGES-1].zero) begin
                n_f[k] = '0;
            end else if (r_dv[stsd_pkg::DV_STAGES-1].neg[k]) begin
                n_f[k] = ~q + 16'd1;
            end else begin
                n_f[k] = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f;
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_dv_vld[stsd_pkg::DV_STAGES-1];
        end
    end

    assign o_vld = r_f_vld;
    assign o_m   = r_f;

endmodule

// ----- rtl/stsd_merge.sv -----
// merge stage: joins corners and lane midpoints and plays out four triangles
module stsd_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  stsd_pkg::t_corner i_crn,
    input  stsd_pkg::t_vec    i_ab,
    input  stsd_pkg::t_vec    i_bc,
    input  stsd_pkg::t_vec    i_ca,
    output logic              o_valid,
    output stsd_pkg::t_tri    o_tri
);

    stsd_pkg::t_corner r_crn;
    stsd_pkg::t_vec    r_ab, r_bc, r_ca;
    logic              r_act, n_act;
    stsd_pkg::t_phase  r_phase, n_phase;

    always_comb begin
        n_act   = r_act;
        n_phase = r_phase;
        if (i_vld) begin
            n_act   = 1'b1;
            n_phase = stsd_pkg::PH_A;
        end else if (r_act) begin
            case (r_phase)
                stsd_pkg::PH_A: begin
                    n_phase = stsd_pkg::PH_B;
                end
                stsd_pkg::PH_B: begin
                    n_phase = stsd_pkg::PH_C;
                end
                stsd_pkg::PH_C: begin
                    n_phase = stsd_pkg::PH_MID;
                end
                default: begin
                    n_phase = stsd_pkg::PH_A;
                    n_act   = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_crn <= i_crn;
            r_ab  <= i_ab;
            r_bc  <= i_bc;
            r_ca  <= i_ca;
        end
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_phase <= stsd_pkg::PH_A;
        end else begin
            r_act   <= n_act;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        o_tri.last_of_four = 1'b0;
        o_tri.mesh_end     = 1'b0;
        case (r_phase)
            stsd_pkg::PH_A: begin
                o_tri.p0 = r_crn.a;
                o_tri.p1 = r_ab;
                o_tri.p2 = r_ca;
            end
            stsd_pkg::PH_B: begin
                o_tri.p0 = r_crn.b;
                o_tri.p1 = r_bc;
                o_tri.p2 = r_ab;
            end
            stsd_pkg::PH_C: begin
                o_tri.p0 = r_crn.c;
                o_tri.p1 = r_ca;
                o_tri.p2 = r_bc;
            end
            default: begin
                o_tri.p0           = r_ab;
                o_tri.p1           = r_bc;
                o_tri.p2           = r_ca;
                o_tri.last_of_four = 1'b1;
                o_tri.mesh_end     = r_crn.last;
            end
        endcase
    end

    assign o_valid = r_act;

endmodule

// ----- rtl/sphere_triangle_subdivider.sv -----
// top level: splits one sphere triangle into four with projected edge midpoints
//
// A triangle (three Q2.14 vertices and a mesh-last flag) is taken at a rising
// edge where start is high and busy is low. busy then goes high and holds off
// the next triangle until its gap counter has run down to zero.
// Three midpoint lanes run side by side, each a 21-stage pipeline (squares,
// a 2-bit-per-stage square root, a 2-bit-per-stage restoring divide). While
// they work, the corners wait in a small queue.
// o_valid marks each result beat; it is high for exactly one cycle per
// triangle and cannot be held off. The four triangles of one input come back to
// back, after the input register, the lane pipelines and the merge register;
// order is (a,ab,ca), (b,bc,ab), (c,ca,bc), (ab,bc,ca), the last one with
// o_last_of_four set and o_mesh_end copied from the input flag.
// The spacing between taken triangles is set by the single result port
// carrying four triangles per input.
// A synchronous reset empties the pipeline and the queue and drops busy.
module sphere_triangle_subdivider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_ax,
    input  logic [15:0] i_ay,
    input  logic [15:0] i_az,
    input  logic [15:0] i_bx,
    input  logic [15:0] i_by,
    input  logic [15:0] i_bz,
    input  logic [15:0] i_cx,
    input  logic [15:0] i_cy,
    input  logic [15:0] i_cz,
    input  logic        i_mesh_last_in,
    output logic        o_valid,
    output logic [15:0] o_p0x,
    output logic [15:0] o_p0y,
    output logic [15:0] o_p0z,
    output logic [15:0] o_p1x,
    output logic [15:0] o_p1y,
    output logic [15:0] o_p1z,
    output logic [15:0] o_p2x,
    output logic [15:0] o_p2y,
    output logic [15:0] o_p2z,
    output logic        o_last_of_four,
    output logic        o_mesh_end
);

    logic                        w_accept;
    logic [1:0]                  r_gap;
    logic                        r_in_vld;
    stsd_pkg::t_vec              r_a, r_b, r_c;
    stsd_pkg::t_vec              w_p [3];
    stsd_pkg::t_vec              w_q [3];
    stsd_pkg::t_vec              w_mid [3];
    logic                        w_lvld [3];
    stsd_pkg::t_corner           r_fifo [stsd_pkg::FIFO_DEPTH];
    logic [stsd_pkg::FIFO_AW-1:0] r_wr, r_rd;
    stsd_pkg::t_tri              w_tri;

    assign w_accept = start && !busy;
    assign busy     = (r_gap != 2'd0);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a <= {i_az, i_ay, i_ax};
            r_b <= {i_bz, i_by, i_bx};
            r_c <= {i_cz, i_cy, i_cx};
            r_fifo[r_wr] <= {i_az, i_ay, i_ax, i_bz, i_by, i_bx,
                             i_cz, i_cy, i_cx, i_mesh_last_in};
        end
        if (!i_rst_n) begin
            r_gap    <= 2'd0;
            r_in_vld <= 1'b0;
            r_wr     <= '0;
            r_rd     <= '0;
        end else begin
            r_in_vld <= w_accept;
            if (w_accept) begin
                r_gap <= 2'd3;
                r_wr  <= r_wr + 1'b1;
            end else if (r_gap != 2'd0) begin
                r_gap <= r_gap - 2'd1;
            end
            if (w_lvld[0]) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    // lane 0: ab, lane 1: bc, lane 2: ca
    assign w_p[0] = r_a;
    assign w_q[0] = r_b;
    assign w_p[1] = r_b;
    assign w_q[1] = r_c;
    assign w_p[2] = r_c;
    assign w_q[2] = r_a;

    genvar l;
    generate
        for (l = 0; l < 3; l++) begin : g_lane
            stsd_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_vld   (r_in_vld),
                .i_p     (w_p[l]),
                .i_q     (w_q[l]),
                .o_vld   (w_lvld[l]),
                .o_m     (w_mid[l])
            );
        end
    endgenerate

    stsd_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_lvld[0]),
        .i_crn   (r_fifo[r_rd]),
        .i_ab    (w_mid[0]),
        .i_bc    (w_mid[1]),
        .i_ca    (w_mid[2]),
        .o_valid (o_valid),
        .o_tri   (w_tri)
    );

    assign o_p0x          = w_tri.p0[0];
    assign o_p0y          = w_tri.p0[1];
    assign o_p0z          = w_tri.p0[2];
    assign o_p1x          = w_tri.p1[0];
    assign o_p1y          = w_tri.p1[1];
    assign o_p1z          = w_tri.p1[2];
    assign o_p2x          = w_tri.p2[0];
    assign o_p2y          = w_tri.p2[1];
    assign o_p2z          = w_tri.p2[2];
    assign o_last_of_four = w_tri.last_of_four;
    assign o_mesh_end     = w_tri.mesh_end;

    a_gap_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy not raised after a taken triangle");

    a_fifo_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lvld[0] |-> (r_wr != r_rd))
        else $error("midpoints arrived with no corners queued");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lvld[0] == w_lvld[1]) && (w_lvld[1] == w_lvld[2]))
        else $error("midpoint lanes out of step");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_four |=> o_valid)
        else $error("result burst broken before fourth triangle");

    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mesh_end |-> o_last_of_four)
        else $error("mesh end flagged on an inner triangle");

endmodule
